// File: design/sem_pkg.sv
package sem_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int ColW      = 10;
    localparam int RowW      = 12;
    localparam int CntRowW   = 13;
    localparam int PixW      = 24;

    localparam logic [ColW-1:0] COL_ONE = ColW'(1);

    typedef logic [PixW-1:0] pixel_t;

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // Input item kinds.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Line store access from the control unit.
    typedef struct packed {
        logic            en;
        logic [ColW-1:0] addr;
        pixel_t          wdata;
    } line_req_t;

    // Per-item context passed to the magnitude stage.
    typedef struct packed {
        logic            emit;
        logic            col_zero;
        logic            top_ok;
        logic            mid_ok;
        pixel_t          bot;
        logic [RowW-1:0] orow;
        logic [ColW-1:0] ocol;
        logic            last;
    } item_ctx_t;

endpackage

// File: design/sem_line_ram.sv
module sem_line_ram (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sem_pkg::line_req_t     req,
    output sem_pkg::pixel_t        upper_q,
    output sem_pkg::pixel_t        middle_q
);

    sem_pkg::pixel_t upper_mem  [sem_pkg::MaxWidth];
    sem_pkg::pixel_t middle_mem [sem_pkg::MaxWidth];
    logic                     move_reg;
    logic [sem_pkg::ColW-1:0] move_addr_reg;

    // Both rows are read at one column and the new pixel takes the middle
    // row's place.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            upper_q  <= upper_mem[req.addr];
            middle_q <= middle_mem[req.addr];
            middle_mem[req.addr] <= req.wdata;
        end
    end

    // In the cycle after, the old middle pixel moves up to the upper row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_reg <= 1'b0;
        end
        else
        begin
            move_reg <= req.en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            move_addr_reg <= req.addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_reg)
        begin
            upper_mem[move_addr_reg] <= middle_q;
        end
    end

endmodule

// File: design/sem_mag.sv
module sem_mag (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    input  sem_pkg::item_ctx_t      ctx,
    input  sem_pkg::pixel_t         upper_q,
    input  sem_pkg::pixel_t         middle_q,
    output logic                    busy,
    output logic                    res_valid,
    output logic [23:0]             res_data,
    output logic [sem_pkg::RowW-1:0] res_row,
    output logic [sem_pkg::ColW-1:0] res_col,
    output logic                    res_last
);

    sem_pkg::pixel_t win_reg [9];
    sem_pkg::pixel_t win_next [9];
    sem_pkg::pixel_t newc [3];
    sem_pkg::pixel_t top;
    sem_pkg::pixel_t mid;
    logic [20:0] nsq [3];
    logic [20:0] n_reg [3];
    logic [7:0]  root_reg [3];
    logic [7:0]  root_next [3];
    logic [7:0]  trial [3];
    logic [15:0] trial_sq [3];
    logic [16:0] lim [3];
    logic [7:0]  mag [3];
    logic [2:0]  bit_reg;
    logic        run_reg;
    logic        round_reg;

    assign top = ctx.top_ok ? upper_q  : '0;
    assign mid = ctx.mid_ok ? middle_q : '0;

    // Column entering the window; a zero column at the left edge.
    always_comb
    begin
        newc[0] = ctx.col_zero ? '0 : top;
        newc[1] = ctx.col_zero ? '0 : mid;
        newc[2] = ctx.col_zero ? '0 : ctx.bot;
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i+3];
        end
        for (int i = 0; i < 3; i++)
        begin
            win_next[6+i] = newc[i];
        end
    end

    // Sobel sums per channel on the shifted window.
    always_comb
    begin
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic [7:0] p [9];
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                p[k] = win_next[k][c*8 +: 8];
            end
            gx = 12'(p[6]) + 12'(2 * p[7]) + 12'(p[8])
               - 12'(p[0]) - 12'(2 * p[1]) - 12'(p[2]);
            gy = 12'(p[2]) + 12'(2 * p[5]) + 12'(p[8])
               - 12'(p[0]) - 12'(2 * p[3]) - 12'(p[6]);
            nsq[c] = 21'(24'(gx * gx) + 24'(gy * gy));
        end
    end

    // Window update; cleared at frame end; left edge restarts with the new column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (valid)
            begin
                if (ctx.emit && ctx.last)
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                end
                else if (ctx.col_zero)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                    win_reg[6] <= top;
                    win_reg[7] <= mid;
                    win_reg[8] <= ctx.bot;
                end
                else
                begin
                    win_reg <= win_next;
                end
            end
        end
    end

    // One root bit per cycle, most significant first, and the final rounding.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c]     = root_reg[c] | (8'd1 << bit_reg);
            trial_sq[c]  = 16'(trial[c]) * 16'(trial[c]);
            root_next[c] = (21'(trial_sq[c]) <= n_reg[c]) ? trial[c] : root_reg[c];
            lim[c]       = 17'(root_reg[c]) * 17'(root_reg[c]) + 17'(root_reg[c]);
            mag[c]       = (n_reg[c] > 21'd65025) ? 8'd255 :
                           ((n_reg[c] > 21'(lim[c])) ? root_reg[c] + 8'd1 : root_reg[c]);
        end
    end

    // Square root sequencing: a bit-by-bit search of the root, then a rounding step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            round_reg <= 1'b0;
            bit_reg   <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= round_reg;
            round_reg <= run_reg && bit_reg == 3'd0;
            if (valid && ctx.emit)
            begin
                run_reg <= 1'b1;
                bit_reg <= 3'd7;
            end
            else if (run_reg)
            begin
                if (bit_reg == 3'd0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    bit_reg <= bit_reg - 3'd1;
                end
            end
        end
    end

    assign busy = run_reg || round_reg;

    // Squared magnitudes, partial roots and the result register.
    always_ff @(posedge clk)
    begin
        if (valid && ctx.emit)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c]    <= nsq[c];
                root_reg[c] <= '0;
            end
            res_row  <= ctx.orow;
            res_col  <= ctx.ocol;
            res_last <= ctx.last;
        end
        else if (run_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                root_reg[c] <= root_next[c];
            end
        end
        if (round_reg)
        begin
            res_data <= {mag[2], mag[1], mag[0]};
        end
    end

endmodule

// File: design/sobel_edge_magnitude_rgb.sv
// Streaming RGB Sobel edge magnitude over a 3x3 window.
// Input s_axis: tdata = red, green, blue from bit 0 up, tuser = op
// (0 pixel, 1 flush). Pixels arrive in raster order; after the frame's
// last pixel, flush transfers drain the remaining outputs.
// Output m_axis: tdata = red, green, blue magnitudes, row, column; tlast
// marks the final pixel of the frame.
// Output m is produced by the input that delivers pixel m+W+1.
// One item is in flight at a time. An accepted item first reads both line
// stores, then forms the window and the squared gradients; an item without
// an output ends there, and the next item is taken after it. An item with
// an output then runs a bit-serial square root and a rounding step; its
// result is registered and then offered on m_tvalid from the output register,
// and no new item is taken until the result has left the magnitude stage.
// An output sits in a register until taken; while it waits, no new item is
// accepted, so a stalled receiver stalls the input.
// Frame size is set over APB: frame_width at 0x0, frame_height at 0x4.
// Reset restores 640x480 and frame start; line stores need no clearing,
// as rows above the frame are masked.
module sobel_edge_magnitude_rgb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_col, pad
    output logic        m_tlast    // frame_last
);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [sem_pkg::ColW-1:0] icol_reg, icol_next;
    logic [sem_pkg::CntRowW-1:0] irow_reg, irow_next;
    logic [sem_pkg::ColW-1:0] ocol_reg, ocol_next;
    logic [sem_pkg::CntRowW-1:0] orow_reg, orow_next;
    logic busy_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic drain, emit, last, take;
    logic [10:0] col_inc;
    logic [10:0] ocol_inc;
    sem_pkg::line_req_t req;
    sem_pkg::item_ctx_t ctx_reg, ctx_next;
    sem_pkg::pixel_t upper_q, middle_q;
    logic mag_busy;
    logic res_valid;
    logic [23:0] res_data;
    logic [sem_pkg::RowW-1:0] res_row;
    logic [sem_pkg::ColW-1:0] res_col;
    logic res_last;
    logic out_valid_reg;
    logic reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
        end
        else if (reg_wr && paddr[1:0] == 2'b00 && paddr[2] == sem_pkg::REG_WIDTH)
        begin
            width_reg <= pwdata[10:0];
        end
        else if (reg_wr && paddr[1:0] == 2'b00 && paddr[2] == sem_pkg::REG_HEIGHT)
        begin
            height_reg <= pwdata[12:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            sem_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            sem_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // Size clamped to the supported range.
    assign w_eff = (width_reg == '0) ? 11'd1 :
                   (width_reg > 11'(sem_pkg::MaxWidth)) ? 11'(sem_pkg::MaxWidth) : width_reg;
    assign h_eff = (height_reg == '0) ? 13'd1 :
                   (height_reg > 13'(sem_pkg::MaxHeight)) ? 13'(sem_pkg::MaxHeight) : height_reg;

    assign s_tready = !busy_reg && !mag_busy && !res_valid && !(out_valid_reg && !m_tready);
    assign take     = s_tvalid && s_tready;

    // Position bookkeeping per accepted pixel or draining flush.
    always_comb
    begin
        drain    = irow_reg >= h_eff;
        emit     = irow_reg >= 13'd2 || (irow_reg == 13'd1 && icol_reg >= sem_pkg::COL_ONE);
        last     = orow_reg >= h_eff ||
                   (orow_reg >= h_eff - 13'd1 && 11'(ocol_reg) >= w_eff - 11'd1);
        col_inc  = 11'(icol_reg) + 11'd1;
        ocol_inc = 11'(ocol_reg) + 11'd1;
        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        req.en    = 1'b0;
        req.addr  = icol_reg;
        req.wdata = drain ? '0 : s_tdata;
        ctx_next.emit     = emit;
        ctx_next.col_zero = icol_reg == '0;
        ctx_next.top_ok   = irow_reg >= 13'd2;
        ctx_next.mid_ok   = irow_reg >= 13'd1;
        ctx_next.bot      = drain ? '0 : s_tdata;
        ctx_next.orow     = orow_reg[sem_pkg::RowW-1:0];
        ctx_next.ocol     = ocol_reg;
        ctx_next.last     = last;
        if (take && (drain || s_tuser == sem_pkg::OP_PIXEL))
        begin
            req.en = 1'b1;
            if (col_inc >= w_eff)
            begin
                icol_next = '0;
                irow_next = irow_reg + 13'd1;
            end
            else
            begin
                icol_next = col_inc[sem_pkg::ColW-1:0];
            end
            if (emit && last)
            begin
                icol_next = '0;
                irow_next = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else if (emit)
            begin
                if (ocol_inc >= w_eff)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + 13'd1;
                end
                else
                begin
                    ocol_next = ocol_inc[sem_pkg::ColW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            busy_reg <= req.en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            ctx_reg <= ctx_next;
        end
    end

    sem_line_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .upper_q  (upper_q),
        .middle_q (middle_q)
    );

    sem_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (busy_reg),
        .ctx       (ctx_reg),
        .upper_q   (upper_q),
        .middle_q  (middle_q),
        .busy      (mag_busy),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_last  (res_last)
    );

    // Output holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata <= {2'b00, res_col, res_row, res_data[23:16], res_data[15:8],
                        res_data[7:0]};
            m_tlast <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid_reg && !m_tready))
        else $error("result overwrote a pending transfer");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.en)
        else $error("second item started during magnitude stage");
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (req.en && ctx_next.emit && ctx_next.last) |=> (irow_reg == '0 && orow_reg == '0))
        else $error("frame counters not cleared after last output");
`endif

endmodule
